// ===== hw/rtl/cfskd_pkg.sv =====
// Shared types, constants and tables of the coherent FSK correlation receiver.
// Holds the sine table builder, the microcode program and the control structs.
// Depends on nothing; every other file of the block uses it.
package cfskd_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W    = 16;
    localparam int ROM_W       = 16;
    localparam int SINE_ADDR_W = 10;
    localparam int SINE_DEPTH  = 1 << SINE_ADDR_W;
    localparam int PHASE_W     = 32;
    localparam int SUM_W       = 44;
    localparam int SPB_W       = 13;
    localparam int MAX_SPB     = 4096;
    localparam int AMP_W       = 16;
    localparam int THR_W       = 60;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 60;

    // Shared multiplier: the metric is split into two halves for the scaling.
    localparam int HALF_W   = SUM_W / 2;
    localparam int MUL_A_W  = HALF_W + 1;
    localparam int MUL_B_W  = AMP_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SCALED_W = THR_W + 1;

    // Register reset values.
    localparam logic [SPB_W-1:0]   SPB_RESET        = SPB_W'(16);
    localparam logic [PHASE_W-1:0] STEP_SPACE_RESET = 32'h3000_0000;
    localparam logic [PHASE_W-1:0] STEP_MARK_RESET  = 32'h4000_0000;
    localparam logic [AMP_W-1:0]   AMP_RESET        = AMP_W'(8192);

    // Sine table generation constants.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef logic signed [ROM_W-1:0] t_sine_table [SINE_DEPTH];

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_BIT    = 3'd0,
        CFG_PHASE_STEP_SPACE   = 3'd1,
        CFG_PHASE_STEP_MARK    = 3'd2,
        CFG_PHASE_OFFSET       = 3'd3,
        CFG_REF_AMPLITUDE      = 3'd4,
        CFG_DECISION_THRESHOLD = 3'd5
    } t_cfg_idx;

    // Program steps.
    typedef enum logic [2:0] {
        STEP_WAIT      = 3'd0,
        STEP_MUL_SPACE = 3'd1,
        STEP_MUL_MARK  = 3'd2,
        STEP_ACC_MARK  = 3'd3,
        STEP_METRIC    = 3'd4,
        STEP_SCALE_LO  = 3'd5,
        STEP_SCALE_HI  = 3'd6,
        STEP_DECIDE    = 3'd7
    } t_step;

    // Sequencing conditions of a control word.
    typedef enum logic [1:0] {
        SQ_NEXT        = 2'd0,
        SQ_WAIT_IN     = 2'd1,
        SQ_BR_NODUMP   = 2'd2,
        SQ_WAIT_OUT_BR = 2'd3
    } t_seq_cond;

    typedef enum logic [1:0] {
        MUL_SAMPLE_REF = 2'd0,
        MUL_METRIC_LO  = 2'd1,
        MUL_METRIC_HI  = 2'd2
    } t_mul_sel;

    typedef enum logic {
        REF_SPACE = 1'b0,
        REF_MARK  = 1'b1
    } t_ref_sel;

    // One control word of the program.
    typedef struct packed {
        t_seq_cond cond;
        t_step     target;
        logic      in_ready;
        t_ref_sel  ref_sel;
        t_mul_sel  mul_sel;
        logic      mul_en;
        logic      acc_space;
        logic      acc_mark;
        logic      step_phase;
        logic      calc_metric;
        logic      save_lo;
        logic      decide;
    } t_ctrl;

    // Status returned by the datapath to the sequencer.
    typedef struct packed {
        logic dump;
        logic out_free;
    } t_stat;

    // Microcode table: one control word per step.
    function automatic t_ctrl micro_word(input t_step step);
        t_ctrl w;
        w = '0;
        w.cond    = SQ_NEXT;
        w.target  = STEP_WAIT;
        w.ref_sel = REF_SPACE;
        w.mul_sel = MUL_SAMPLE_REF;
        case (step)
            STEP_WAIT: begin
                w.cond     = SQ_WAIT_IN;
                w.in_ready = 1'b1;
            end
            STEP_MUL_SPACE: begin
                w.ref_sel = REF_MARK;
                w.mul_en  = 1'b1;
            end
            STEP_MUL_MARK: begin
                w.mul_en     = 1'b1;
                w.acc_space  = 1'b1;
                w.step_phase = 1'b1;
            end
            STEP_ACC_MARK: begin
                w.cond     = SQ_BR_NODUMP;
                w.acc_mark = 1'b1;
            end
            STEP_METRIC: begin
                w.calc_metric = 1'b1;
            end
            STEP_SCALE_LO: begin
                w.mul_sel = MUL_METRIC_LO;
                w.mul_en  = 1'b1;
            end
            STEP_SCALE_HI: begin
                w.mul_sel = MUL_METRIC_HI;
                w.mul_en  = 1'b1;
                w.save_lo = 1'b1;
            end
            STEP_DECIDE: begin
                w.cond   = SQ_WAIT_OUT_BR;
                w.decide = 1'b1;
            end
            default: begin
                w.cond = SQ_BR_NODUMP;
            end
        endcase
        return w;
    endfunction

    // Sine table: fixed-point Taylor series up to x^13 on the folded angle.
    function automatic t_sine_table build_sine_table();
        t_sine_table     tbl;
        longint unsigned turn;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned val;
        logic [1:0]      quad;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            turn = longint'(i) << (PHASE_W - SINE_ADDR_W);
            quad = turn[31:30];
            r    = turn & (ONE_Q30 - 64'd1);
            if (quad[0]) begin
                r = ONE_Q30 - r;
            end
            x    = (r * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 6; k++) begin
                term = (term * x2) >> 30;
                case (k)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    default: term = term / 156;
                endcase
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            val = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            if (quad[1]) begin
                tbl[i] = -$signed(val[ROM_W-1:0]);
            end else begin
                tbl[i] = $signed(val[ROM_W-1:0]);
            end
        end
        return tbl;
    endfunction

endpackage

// ===== hw/rtl/cfskd_sine_rom.sv =====
// Quarter-wave-free full sine ROM of the reference generator, registered read.
// Contents come from the table builder in cfskd_pkg.
module cfskd_sine_rom (
    input  logic                                    i_clk,
    input  logic [cfskd_pkg::SINE_ADDR_W-1:0]       i_addr,
    output logic signed [cfskd_pkg::ROM_W-1:0]      o_data
);

    localparam cfskd_pkg::t_sine_table SINE_TABLE = cfskd_pkg::build_sine_table();

    logic signed [cfskd_pkg::ROM_W-1:0] r_data;

    // One read per cycle, data valid on the following cycle.
    always_ff @(posedge i_clk) begin
        r_data <= SINE_TABLE[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/cfskd_seq.sv =====
// Microcoded sequencer: step counter, microcode lookup and conditional jumps.
// Uses the program and control types of cfskd_pkg.
module cfskd_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  cfskd_pkg::t_stat i_stat,
    output cfskd_pkg::t_ctrl o_ctrl
);

    cfskd_pkg::t_step r_pc;
    cfskd_pkg::t_step n_pc;
    cfskd_pkg::t_step pc_inc;
    cfskd_pkg::t_ctrl ctrl;

    assign pc_inc = cfskd_pkg::t_step'(3'(r_pc) + 3'd1);

    // Control word for the current step.
    always_comb begin
        ctrl = cfskd_pkg::micro_word(r_pc);
    end

    // Next step selection.
    always_comb begin
        case (ctrl.cond)
            cfskd_pkg::SQ_NEXT:        n_pc = pc_inc;
            cfskd_pkg::SQ_WAIT_IN:     n_pc = i_in_valid ? pc_inc : r_pc;
            cfskd_pkg::SQ_BR_NODUMP:   n_pc = i_stat.dump ? pc_inc : ctrl.target;
            cfskd_pkg::SQ_WAIT_OUT_BR: n_pc = i_stat.out_free ? ctrl.target : r_pc;
            default:                   n_pc = cfskd_pkg::STEP_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cfskd_pkg::STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

// ===== hw/rtl/cfskd_datapath.sv =====
// Datapath: configuration registers, phase accumulators, shared multiplier,
// window sums, metric, decision and the output register. Uses cfskd_pkg and
// the sine ROM module.
module cfskd_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cfskd_pkg::t_ctrl                      i_ctrl,
    output cfskd_pkg::t_stat                      o_stat,
    input  logic                                  i_cfg_we,
    input  logic [cfskd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cfskd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_in_valid,
    input  logic signed [cfskd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                  i_last_sample,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic                                  o_bit_res,
    output logic signed [cfskd_pkg::SUM_W-1:0]    o_metric,
    output logic                                  o_partial_window,
    output logic                                  o_is_last
);

    localparam int SW = cfskd_pkg::SUM_W;
    localparam int HW = cfskd_pkg::HALF_W;
    localparam int PW = cfskd_pkg::PROD_W;
    localparam int XW = cfskd_pkg::SCALED_W;

    // Configuration registers.
    logic [cfskd_pkg::SPB_W-1:0]   r_spb;
    logic [cfskd_pkg::PHASE_W-1:0] r_step_space;
    logic [cfskd_pkg::PHASE_W-1:0] r_step_mark;
    logic [cfskd_pkg::PHASE_W-1:0] r_offset;
    logic [cfskd_pkg::AMP_W-1:0]   r_amp;
    logic [cfskd_pkg::THR_W-1:0]   r_thr;

    // Working state.
    logic [cfskd_pkg::PHASE_W-1:0]         r_space_phase;
    logic [cfskd_pkg::PHASE_W-1:0]         r_mark_phase;
    logic [cfskd_pkg::SPB_W-1:0]           r_count;
    logic signed [SW-1:0]                  r_space_sum;
    logic signed [SW-1:0]                  r_mark_sum;
    logic signed [cfskd_pkg::SAMPLE_W-1:0] r_sample;
    logic                                  r_last;
    logic signed [PW-1:0]                  r_prod;
    logic signed [PW-1:0]                  r_scaled_lo;
    logic signed [SW-1:0]                  r_metric;
    logic                                  r_partial;

    // Output register.
    logic                 r_out_valid;
    logic                 r_bit_res;
    logic signed [SW-1:0] r_out_metric;
    logic                 r_out_partial;
    logic                 r_out_last;

    logic                               in_beat;
    logic                               out_free;
    logic                               out_load;
    logic [cfskd_pkg::SPB_W-1:0]        spb_eff;
    logic                               window_full;
    logic [cfskd_pkg::PHASE_W-1:0]      ref_phase;
    logic signed [cfskd_pkg::ROM_W-1:0] rom_data;
    logic signed [cfskd_pkg::MUL_A_W-1:0] mul_a;
    logic signed [cfskd_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]               mul_p;
    logic signed [SW:0]                 diff;
    logic signed [SW-1:0]               metric_sat;
    logic signed [XW-1:0]               scaled;
    logic signed [XW-1:0]               thr_ext;

    assign in_beat  = i_in_valid && i_ctrl.in_ready;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = i_ctrl.decide && out_free;

    // Window length clamped to the supported range.
    always_comb begin
        if (r_spb == '0) begin
            spb_eff = cfskd_pkg::SPB_W'(1);
        end else if (r_spb > cfskd_pkg::SPB_W'(cfskd_pkg::MAX_SPB)) begin
            spb_eff = cfskd_pkg::SPB_W'(cfskd_pkg::MAX_SPB);
        end else begin
            spb_eff = r_spb;
        end
    end

    assign window_full     = (r_count >= spb_eff);
    assign o_stat.dump     = r_last || window_full;
    assign o_stat.out_free = out_free;

    // Reference address: top bits of the selected phase plus the offset.
    assign ref_phase = ((i_ctrl.ref_sel == cfskd_pkg::REF_MARK) ? r_mark_phase
                                                                 : r_space_phase) + r_offset;

    cfskd_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (ref_phase[cfskd_pkg::PHASE_W-1 -: cfskd_pkg::SINE_ADDR_W]),
        .o_data (rom_data)
    );

    // Shared multiplier operand selection.
    always_comb begin
        case (i_ctrl.mul_sel)
            cfskd_pkg::MUL_METRIC_LO: begin
                mul_a = $signed({1'b0, r_metric[HW-1:0]});
                mul_b = $signed({1'b0, r_amp});
            end
            cfskd_pkg::MUL_METRIC_HI: begin
                mul_a = $signed({r_metric[SW-1], r_metric[SW-1:HW]});
                mul_b = $signed({1'b0, r_amp});
            end
            default: begin
                mul_a = cfskd_pkg::MUL_A_W'(r_sample);
                mul_b = cfskd_pkg::MUL_B_W'(rom_data);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Saturated difference of the window sums.
    assign diff = SW'(r_mark_sum) - SW'(r_space_sum) + (SW+1)'(0);
    always_comb begin
        if (diff[SW] != diff[SW-1]) begin
            metric_sat = diff[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            metric_sat = diff[SW-1:0];
        end
    end

    // Scaled metric rebuilt from the two partial products.
    assign scaled  = (XW'(r_prod) <<< HW) + XW'(r_scaled_lo);
    assign thr_ext = XW'($signed(r_thr));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb        <= cfskd_pkg::SPB_RESET;
            r_step_space <= cfskd_pkg::STEP_SPACE_RESET;
            r_step_mark  <= cfskd_pkg::STEP_MARK_RESET;
            r_offset     <= '0;
            r_amp        <= cfskd_pkg::AMP_RESET;
            r_thr        <= '0;
        end else if (i_cfg_we) begin
            case (cfskd_pkg::t_cfg_idx'(i_cfg_index))
                cfskd_pkg::CFG_SAMPLES_PER_BIT:
                    r_spb <= i_cfg_data[cfskd_pkg::SPB_W-1:0];
                cfskd_pkg::CFG_PHASE_STEP_SPACE:
                    r_step_space <= i_cfg_data[cfskd_pkg::PHASE_W-1:0];
                cfskd_pkg::CFG_PHASE_STEP_MARK:
                    r_step_mark <= i_cfg_data[cfskd_pkg::PHASE_W-1:0];
                cfskd_pkg::CFG_PHASE_OFFSET:
                    r_offset <= i_cfg_data[cfskd_pkg::PHASE_W-1:0];
                cfskd_pkg::CFG_REF_AMPLITUDE:
                    r_amp <= i_cfg_data[cfskd_pkg::AMP_W-1:0];
                cfskd_pkg::CFG_DECISION_THRESHOLD:
                    r_thr <= i_cfg_data[cfskd_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input capture and multiplier products.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_sample <= i_sample;
            r_last   <= i_last_sample;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_ctrl.save_lo) begin
            r_scaled_lo <= r_prod;
        end
        if (i_ctrl.calc_metric) begin
            r_metric  <= metric_sat;
            r_partial <= r_last && !window_full;
        end
    end

    // Phases, count and window sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_phase <= '0;
            r_mark_phase  <= '0;
            r_count       <= '0;
            r_space_sum   <= '0;
            r_mark_sum    <= '0;
        end else begin
            if (i_ctrl.step_phase) begin
                r_space_phase <= r_space_phase + r_step_space;
                r_mark_phase  <= r_mark_phase + r_step_mark;
                r_count       <= r_count + cfskd_pkg::SPB_W'(1);
            end
            if (i_ctrl.acc_space) begin
                r_space_sum <= r_space_sum + SW'(r_prod);
            end
            if (i_ctrl.acc_mark) begin
                r_mark_sum <= r_mark_sum + SW'(r_prod);
            end
            if (out_load) begin
                r_count     <= '0;
                r_space_sum <= '0;
                r_mark_sum  <= '0;
                if (r_last) begin
                    r_space_phase <= '0;
                    r_mark_phase  <= '0;
                end
            end
        end
    end

    // Result register: a beat waits here while the sequencer takes new samples.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_bit_res     <= (scaled > thr_ext);
            r_out_metric  <= r_metric;
            r_out_partial <= r_partial;
            r_out_last    <= r_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_bit_res        = r_bit_res;
    assign o_metric         = r_out_metric;
    assign o_partial_window = r_out_partial;
    assign o_is_last        = r_out_last;

endmodule

// ===== hw/rtl/coherent_fsk_correlation_demodulator_unit.sv =====
// Coherent BFSK correlation receiver, integrate and dump, top level.
// Each sample runs the wait, space multiply, mark multiply and mark accumulate
// steps before the next is taken; a window end adds the metric, two-part
// amplitude scaling and decision steps on the one shared multiplier. The
// decision step loads the result beat, waiting while a previous beat stalls.
// Reset: synchronous, active low; registers return to defaults, state to zero.
module coherent_fsk_correlation_demodulator_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [cfskd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cfskd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [cfskd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                  i_last_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_bit_res,
    output logic signed [cfskd_pkg::SUM_W-1:0]    o_metric,
    output logic                                  o_partial_window,
    output logic                                  o_is_last
);

    cfskd_pkg::t_ctrl ctrl;
    cfskd_pkg::t_stat stat;

    // The sequencer takes a sample only in its wait step.
    assign o_in_stall = !ctrl.in_ready;

    cfskd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    cfskd_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_sample         (i_sample),
        .i_last_sample    (i_last_sample),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_bit_res        (o_bit_res),
        .o_metric         (o_metric),
        .o_partial_window (o_partial_window),
        .o_is_last        (o_is_last)
    );

endmodule

// ===== hw/rtl/cfskd_checker.sv =====
// Port-level checker of the FSK correlation receiver and its bind statement.
// Depends on cfskd_pkg and on the top level's port list.
module cfskd_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic                                  o_bit_res,
    input logic signed [cfskd_pkg::SUM_W-1:0]    o_metric,
    input logic                                  o_partial_window,
    input logic                                  o_is_last
);

    // A stalled result beat stays valid.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_metric) && $stable(o_bit_res) &&
        $stable(o_partial_window) && $stable(o_is_last))
        else $error("result payload changed while stalled");

    // A taken sample stalls the input through its multiply and accumulate steps.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("sample beat taken before previous sample finished");

    // Only the end-of-signal dump can cut a window short.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_partial_window |-> o_is_last)
        else $error("partial window without end of signal");

endmodule

bind coherent_fsk_correlation_demodulator_unit cfskd_checker u_chk (.*);
